// ===== rtl/lgt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgt_pkg
// Shared types, constants and helpers of the associated Legendre table block.
// ----------------------------------------------------------------------------
package lgt_pkg;

    localparam int FRAC_BITS = 34;
    localparam int ADDR_W    = 8;
    localparam int K_W       = 5;

    localparam logic signed [63:0] ONE_Q = 64'sh0000_0004_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQRT,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_MTOP,
        S_SPWAIT,
        S_DGWAIT,
        S_OFF,
        S_OFFMUL,
        S_OFFWAIT,
        S_NTOP,
        S_NMUL1,
        S_NW1,
        S_NMUL2,
        S_NW2,
        S_DIVW,
        S_MNEXT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        W_ONE,
        W_CQ,
        W_S,
        W_ZERO,
        W_PROD,
        W_QUOT
    } t_wsel;

    typedef enum logic [1:0] {
        A_SP,
        A_DF,
        A_KCQ,
        A_K
    } t_asel;

    typedef enum logic [1:0] {
        B_S,
        B_RD,
        B_PROD
    } t_bsel;

    typedef struct packed {
        logic              load;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_wsel             wsel;
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              mul_start;
        t_asel             asel;
        t_bsel             bsel;
        logic              frac;
        logic [K_W-1:0]    k;
        logic              sp_init;
        logic              sp_load;
        logic              df_step;
        logic              t1_load;
        logic              div_start;
        logic              emit;
        logic [3:0]        emit_n;
        logic [3:0]        emit_m;
        logic              emit_last;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic mul_done;
        logic div_done;
        logic s_zero;
    } t_stat;

    // triangular index of (n, m)
    function automatic logic [ADDR_W-1:0] tri_addr(input logic [3:0] n, input logic [3:0] m);
        logic [ADDR_W-1:0] nn;
        nn = {4'b0, n};
        return ((nn * (nn + ADDR_W'(1))) >> 1) + {4'b0, m};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lgt_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgt_mul
// Iterative 64x64 signed multiplier, one 32x32 partial product per cycle,
// optional Q29.34 rescale with round half away from zero, saturating.
// ----------------------------------------------------------------------------
module lgt_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    input  wire logic               i_frac,
    output logic                    o_done,
    output logic signed [63:0]      o_prod
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_neg;
    logic         r_frac;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_prod;

    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [31:0]  xa;
    logic [31:0]  xb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] q;
    logic         over;
    logic [63:0]  mag;
    logic signed [63:0] sat;

    always_comb begin
        ua = i_a[63] ? 64'(-i_a) : 64'(i_a);
        ub = i_b[63] ? 64'(-i_b) : 64'(i_b);
        xa = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        xb = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        pp = xa * xb;
        case (r_cnt)
            3'd0:    pp_sh = {64'b0, pp};
            3'd1,
            3'd2:    pp_sh = {32'b0, pp, 32'b0};
            3'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = '0;
        endcase
        q    = r_frac ? (r_acc >> lgt_pkg::FRAC_BITS) : r_acc;
        over = |q[127:64];
        mag  = q[63:0];
        if (r_neg) begin
            if (over || mag[63]) begin
                sat = {1'b1, 63'b0};
            end else begin
                sat = -$signed(mag);
            end
        end else begin
            if (over || mag[63]) begin
                sat = {1'b0, {63{1'b1}}};
            end else begin
                sat = $signed(mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_a[63] ^ i_b[63];
                r_frac <= i_frac;
                r_ua   <= ua;
                r_ub   <= ub;
                // rounding constant preloaded into the accumulator
                r_acc  <= i_frac ? (128'd1 << (lgt_pkg::FRAC_BITS - 1)) : 128'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_prod <= sat;
                end else begin
                    r_acc <= r_acc + pp_sh;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== rtl/lgt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgt_ctrl
// Sequencer: square root, diagonal, off-diagonal and recurrence steps per
// order, then the read-out of the table in index order.
// ----------------------------------------------------------------------------
module lgt_ctrl #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_wdata,
    input  wire lgt_pkg::t_stat i_stat,
    output lgt_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] MAXD = 4'(MAX_DEGREE);

    lgt_pkg::t_state r_state, n_state;
    logic [3:0] r_dl;
    logic [3:0] r_lim, n_lim;
    logic [3:0] r_n, n_n;
    logic [3:0] r_m, n_m;

    logic [lgt_pkg::K_W-1:0] k_m2m1;
    logic [lgt_pkg::K_W-1:0] k_m2p1;
    logic [lgt_pkg::K_W-1:0] k_n2m1;
    logic [lgt_pkg::K_W-1:0] k_nm1;
    logic [lgt_pkg::K_W-1:0] k_nmm;
    logic                    m_ge2;
    logic                    emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgt_pkg::S_IDLE;
            r_dl    <= 4'd8;
            r_lim   <= '0;
            r_n     <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_lim   <= n_lim;
            r_n     <= n_n;
            r_m     <= n_m;
            if (i_cfg_we) begin
                r_dl <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        k_m2m1    = {r_m, 1'b0} - 5'd1;
        k_m2p1    = {r_m, 1'b0} + 5'd1;
        k_n2m1    = {r_n, 1'b0} - 5'd1;
        k_nm1     = {1'b0, r_n} + {1'b0, r_m} - 5'd1;
        k_nmm     = {1'b0, r_n - r_m};
        m_ge2     = r_m >= 4'd2;
        emit_last = (r_n == r_lim) && (r_m == r_n);

        n_state = r_state;
        n_lim   = r_lim;
        n_n     = r_n;
        n_m     = r_m;
        o_cmd   = '0;

        case (r_state)
            lgt_pkg::S_IDLE: begin
                if (start) begin
                    n_lim      = (r_dl > MAXD) ? MAXD : r_dl;
                    o_cmd.load = 1'b1;
                    n_state    = lgt_pkg::S_SQRT;
                end
            end
            lgt_pkg::S_SQRT: begin
                if (i_stat.sqrt_done) begin
                    n_state = lgt_pkg::S_INIT0;
                end
            end
            lgt_pkg::S_INIT0: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = lgt_pkg::tri_addr(4'd0, 4'd0);
                o_cmd.wsel  = lgt_pkg::W_ONE;
                n_state     = lgt_pkg::S_INIT1;
            end
            lgt_pkg::S_INIT1: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = lgt_pkg::tri_addr(4'd1, 4'd0);
                o_cmd.wsel  = lgt_pkg::W_CQ;
                n_state     = lgt_pkg::S_INIT2;
            end
            lgt_pkg::S_INIT2: begin
                o_cmd.we      = 1'b1;
                o_cmd.waddr   = lgt_pkg::tri_addr(4'd1, 4'd1);
                o_cmd.wsel    = lgt_pkg::W_S;
                o_cmd.sp_init = 1'b1;
                n_m           = '0;
                n_state       = lgt_pkg::S_MTOP;
            end
            lgt_pkg::S_MTOP: begin
                if (m_ge2) begin
                    o_cmd.df_step = 1'b1;
                    o_cmd.k       = k_m2m1;
                    if (i_stat.s_zero) begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = lgt_pkg::tri_addr(r_m, r_m);
                        o_cmd.wsel  = lgt_pkg::W_ZERO;
                        n_state     = lgt_pkg::S_OFF;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        o_cmd.asel      = lgt_pkg::A_SP;
                        o_cmd.bsel      = lgt_pkg::B_S;
                        o_cmd.frac      = 1'b1;
                        n_state         = lgt_pkg::S_SPWAIT;
                    end
                end else begin
                    n_state = lgt_pkg::S_OFF;
                end
            end
            lgt_pkg::S_SPWAIT: begin
                if (i_stat.mul_done) begin
                    // diagonal = double factorial times the new sine power
                    o_cmd.sp_load   = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.asel      = lgt_pkg::A_DF;
                    o_cmd.bsel      = lgt_pkg::B_PROD;
                    o_cmd.frac      = 1'b0;
                    n_state         = lgt_pkg::S_DGWAIT;
                end
            end
            lgt_pkg::S_DGWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = lgt_pkg::tri_addr(r_m, r_m);
                    o_cmd.wsel  = lgt_pkg::W_PROD;
                    n_state     = lgt_pkg::S_OFF;
                end
            end
            lgt_pkg::S_OFF: begin
                n_n = r_m + 4'd2;
                if ((r_m >= 4'd1) && (r_m < r_lim)) begin
                    if (m_ge2 && i_stat.s_zero) begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = lgt_pkg::tri_addr(r_m + 4'd1, r_m);
                        o_cmd.wsel  = lgt_pkg::W_ZERO;
                        n_state     = lgt_pkg::S_NTOP;
                    end else begin
                        o_cmd.re    = 1'b1;
                        o_cmd.raddr = lgt_pkg::tri_addr(r_m, r_m);
                        n_state     = lgt_pkg::S_OFFMUL;
                    end
                end else begin
                    n_state = lgt_pkg::S_NTOP;
                end
            end
            lgt_pkg::S_OFFMUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.asel      = lgt_pkg::A_KCQ;
                o_cmd.bsel      = lgt_pkg::B_RD;
                o_cmd.frac      = 1'b1;
                o_cmd.k         = k_m2p1;
                n_state         = lgt_pkg::S_OFFWAIT;
            end
            lgt_pkg::S_OFFWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = lgt_pkg::tri_addr(r_m + 4'd1, r_m);
                    o_cmd.wsel  = lgt_pkg::W_PROD;
                    n_state     = lgt_pkg::S_NTOP;
                end
            end
            lgt_pkg::S_NTOP: begin
                if (r_n <= r_lim) begin
                    o_cmd.re    = 1'b1;
                    o_cmd.raddr = lgt_pkg::tri_addr(r_n - 4'd1, r_m);
                    n_state     = lgt_pkg::S_NMUL1;
                end else begin
                    n_state = lgt_pkg::S_MNEXT;
                end
            end
            lgt_pkg::S_NMUL1: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.asel      = lgt_pkg::A_KCQ;
                o_cmd.bsel      = lgt_pkg::B_RD;
                o_cmd.frac      = 1'b1;
                o_cmd.k         = k_n2m1;
                n_state         = lgt_pkg::S_NW1;
            end
            lgt_pkg::S_NW1: begin
                if (i_stat.mul_done) begin
                    o_cmd.t1_load = 1'b1;
                    o_cmd.re      = 1'b1;
                    o_cmd.raddr   = lgt_pkg::tri_addr(r_n - 4'd2, r_m);
                    n_state       = lgt_pkg::S_NMUL2;
                end
            end
            lgt_pkg::S_NMUL2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.asel      = lgt_pkg::A_K;
                o_cmd.bsel      = lgt_pkg::B_RD;
                o_cmd.frac      = 1'b0;
                o_cmd.k         = k_nm1;
                n_state         = lgt_pkg::S_NW2;
            end
            lgt_pkg::S_NW2: begin
                if (i_stat.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.k         = k_nmm;
                    n_state         = lgt_pkg::S_DIVW;
                end
            end
            lgt_pkg::S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = lgt_pkg::tri_addr(r_n, r_m);
                    o_cmd.wsel  = lgt_pkg::W_QUOT;
                    n_n         = r_n + 4'd1;
                    n_state     = lgt_pkg::S_NTOP;
                end
            end
            lgt_pkg::S_MNEXT: begin
                if (r_m < r_lim) begin
                    n_m     = r_m + 4'd1;
                    n_state = lgt_pkg::S_MTOP;
                end else begin
                    n_n     = '0;
                    n_m     = '0;
                    n_state = lgt_pkg::S_EMIT;
                end
            end
            lgt_pkg::S_EMIT: begin
                o_cmd.re        = 1'b1;
                o_cmd.raddr     = lgt_pkg::tri_addr(r_n, r_m);
                o_cmd.emit      = 1'b1;
                o_cmd.emit_n    = r_n;
                o_cmd.emit_m    = r_m;
                o_cmd.emit_last = emit_last;
                if (r_m == r_n) begin
                    n_n = r_n + 4'd1;
                    n_m = '0;
                end else begin
                    n_m = r_m + 4'd1;
                end
                if (emit_last) begin
                    n_state = lgt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lgt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != lgt_pkg::S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/lgt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgt_dp
// Datapath: bit-pair square root, shared multiplier, small-divisor divider,
// sine power and double factorial registers, scratch table and result port.
// ----------------------------------------------------------------------------
module lgt_dp #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lgt_pkg::t_cmd      i_cmd,
    output lgt_pkg::t_stat          o_stat,
    input  wire logic signed [31:0] i_cos_angle,
    output logic                    o_valid,
    output logic signed [63:0]      o_value,
    output logic [3:0]              o_degree,
    output logic [3:0]              o_order_index,
    output logic                    o_last
);

    localparam int DEPTH = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
    localparam int AW    = $clog2(DEPTH);

    logic signed [63:0] mem [DEPTH];

    logic signed [31:0] r_c32;
    logic signed [63:0] r_cq;
    logic signed [63:0] r_s;
    logic signed [63:0] r_sp;
    logic [31:0]        r_df;
    logic signed [63:0] r_t1;
    logic signed [63:0] r_rd;

    // square root
    logic        r_sq_init;
    logic        r_sq_run;
    logic [4:0]  r_sq_cnt;
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_sq_done;

    // divider
    logic               r_dv_prep;
    logic               r_dv_run;
    logic               r_dv_fin;
    logic               r_dv_done;
    logic [2:0]         r_dv_cnt;
    logic               r_dv_neg;
    logic [3:0]         r_dv_d;
    logic [3:0]         r_dv_rem;
    logic signed [63:0] r_dv_val;
    logic [63:0]        r_dq;
    logic signed [63:0] r_quot;

    // result port
    logic               r_ov;
    logic [3:0]         r_on;
    logic [3:0]         r_om;
    logic               r_ol;

    logic signed [63:0] sq;
    logic signed [63:0] rad;
    logic [63:0]        rb;
    logic               sq_ge;
    logic [63:0]        x_nx;
    logic [63:0]        r_nx;

    logic signed [63:0] kcq;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic               mul_done;
    logic signed [63:0] mul_prod;

    logic signed [64:0] diff;
    logic signed [63:0] diff_sat;
    logic [63:0]        dv_mag;
    logic [4:0]         dv_t;
    logic [3:0]         dv_rem;
    logic [7:0]         dv_q;

    logic signed [63:0] wdata;

    always_comb begin
        sq  = r_c32 * r_c32;
        rad = 64'sh1000_0000_0000_0000 - sq;
        rb    = r_r + r_bit;
        sq_ge = r_x >= rb;
        x_nx  = sq_ge ? (r_x - rb) : r_x;
        r_nx  = sq_ge ? ((r_r >> 1) + r_bit) : (r_r >> 1);

        kcq = 64'($signed({1'b0, i_cmd.k}) * r_cq);
        case (i_cmd.asel)
            lgt_pkg::A_SP:  mul_a = r_sp;
            lgt_pkg::A_DF:  mul_a = $signed({32'b0, r_df});
            lgt_pkg::A_KCQ: mul_a = kcq;
            lgt_pkg::A_K:   mul_a = $signed({59'b0, i_cmd.k});
            default:        mul_a = r_sp;
        endcase
        case (i_cmd.bsel)
            lgt_pkg::B_S:    mul_b = r_s;
            lgt_pkg::B_RD:   mul_b = r_rd;
            lgt_pkg::B_PROD: mul_b = mul_prod;
            default:         mul_b = r_s;
        endcase

        diff = {r_t1[63], r_t1} - {mul_prod[63], mul_prod};
        if (diff[64] != diff[63]) begin
            diff_sat = diff[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            diff_sat = diff[63:0];
        end
        dv_mag = r_dv_val[63] ? 64'(-r_dv_val) : 64'(r_dv_val);

        // eight restoring steps, remainder stays below the divisor
        dv_rem = r_dv_rem;
        dv_q   = '0;
        for (int i = 7; i >= 0; i--) begin
            dv_t = {dv_rem, r_dq[56 + i]};
            if (dv_t >= {1'b0, r_dv_d}) begin
                dv_q[i] = 1'b1;
                dv_rem  = 4'(dv_t - {1'b0, r_dv_d});
            end else begin
                dv_rem = dv_t[3:0];
            end
        end

        case (i_cmd.wsel)
            lgt_pkg::W_ONE:  wdata = lgt_pkg::ONE_Q;
            lgt_pkg::W_CQ:   wdata = r_cq;
            lgt_pkg::W_S:    wdata = r_s;
            lgt_pkg::W_ZERO: wdata = '0;
            lgt_pkg::W_PROD: wdata = mul_prod;
            lgt_pkg::W_QUOT: wdata = r_quot;
            default:         wdata = '0;
        endcase
    end

    lgt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_frac  (i_cmd.frac),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr[AW-1:0]] <= wdata;
        end
        if (i_cmd.re) begin
            r_rd <= mem[i_cmd.raddr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_init <= 1'b0;
            r_sq_run  <= 1'b0;
            r_sq_cnt  <= '0;
            r_sq_done <= 1'b0;
            r_s       <= '0;
            r_sp      <= '0;
            r_df      <= 32'd1;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.load) begin
                r_c32     <= i_cos_angle;
                r_cq      <= {{28{i_cos_angle[31]}}, i_cos_angle, 4'b0};
                r_sq_init <= 1'b1;
            end
            if (r_sq_init) begin
                r_sq_init <= 1'b0;
                r_sq_run  <= 1'b1;
                r_sq_cnt  <= 5'd31;
                r_x       <= rad[63] ? 64'd0 : 64'(rad);
                r_r       <= '0;
                r_bit     <= 64'h4000_0000_0000_0000;
            end
            if (r_sq_run) begin
                r_x      <= x_nx;
                r_r      <= r_nx;
                r_bit    <= r_bit >> 2;
                r_sq_cnt <= r_sq_cnt - 5'd1;
                if (r_sq_cnt == 5'd0) begin
                    r_sq_run  <= 1'b0;
                    r_sq_done <= 1'b1;
                    r_s       <= 64'sd0 - $signed({29'b0, r_nx[30:0], 4'b0});
                end
            end
            if (i_cmd.sp_init) begin
                r_sp <= r_s;
                r_df <= 32'd1;
            end
            if (i_cmd.sp_load) begin
                r_sp <= mul_prod;
            end
            if (i_cmd.df_step) begin
                r_df <= 32'(r_df * {27'b0, i_cmd.k});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.t1_load) begin
            r_t1 <= mul_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_prep <= 1'b0;
            r_dv_run  <= 1'b0;
            r_dv_fin  <= 1'b0;
            r_dv_done <= 1'b0;
            r_dv_cnt  <= '0;
        end else begin
            r_dv_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_dv_val  <= diff_sat;
                r_dv_d    <= i_cmd.k[3:0];
                r_dv_prep <= 1'b1;
            end
            if (r_dv_prep) begin
                r_dv_prep <= 1'b0;
                r_dv_run  <= 1'b1;
                r_dv_cnt  <= 3'd7;
                r_dv_neg  <= r_dv_val[63];
                r_dv_rem  <= '0;
                // half the divisor added first gives round half away from zero
                r_dq      <= dv_mag + {61'b0, r_dv_d[3:1]};
            end
            if (r_dv_run) begin
                r_dq     <= {r_dq[55:0], dv_q};
                r_dv_rem <= dv_rem;
                r_dv_cnt <= r_dv_cnt - 3'd1;
                if (r_dv_cnt == 3'd0) begin
                    r_dv_run <= 1'b0;
                    r_dv_fin <= 1'b1;
                end
            end
            if (r_dv_fin) begin
                r_dv_fin  <= 1'b0;
                r_dv_done <= 1'b1;
                r_quot    <= r_dv_neg ? -$signed(r_dq) : $signed(r_dq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= i_cmd.emit;
        end
        r_on <= i_cmd.emit_n;
        r_om <= i_cmd.emit_m;
        r_ol <= i_cmd.emit_last;
    end

    assign o_stat.sqrt_done = r_sq_done;
    assign o_stat.mul_done  = mul_done;
    assign o_stat.div_done  = r_dv_done;
    assign o_stat.s_zero    = (r_s == 64'sd0);

    assign o_valid       = r_ov;
    assign o_value       = r_rd;
    assign o_degree      = r_on;
    assign o_order_index = r_om;
    assign o_last        = r_ol & r_ov;

endmodule
`default_nettype wire

// ===== rtl/associated_legendre_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// associated_legendre_table
// Associated Legendre values Pn^m(cos) for 0 <= m <= n <= degree limit,
// emitted in index order with the last one flagged.
// ----------------------------------------------------------------------------
// sequence: square root, then per order the diagonal, the off-diagonal and the
//   recurrence steps (two products on the shared multiplier, then the divider)
// a new start is taken only in idle, after the read-out of the last set; results
//   come at one a cycle during the final read-out; the receiver cannot stall
// reset: synchronous, active low; degree limit returns to 8
module associated_legendre_table #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_cos_angle,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_wdata,
    output logic                    o_valid,
    output logic signed [63:0]      o_value,
    output logic [3:0]              o_degree,
    output logic [3:0]              o_order_index,
    output logic                    o_last
);

    lgt_pkg::t_cmd  cmd;
    lgt_pkg::t_stat stat;

    lgt_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lgt_dp #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cos_angle   (i_cos_angle),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_degree      (o_degree),
        .o_order_index (o_order_index),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ===== sim/tb_associated_legendre_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_associated_legendre_table
// Drives cosines into the Legendre table block, predicts every Pn^m value of
// each set and compares the result stream field by field, over several
// degree limits, with random gaps on the sending side.
// ----------------------------------------------------------------------------
module tb_associated_legendre_table;

    localparam int MAX_DEG    = 8;
    localparam int FRAC       = 34;
    localparam int STALL_MAX  = 20000;
    localparam int SETTLE_CYC = 1200;
    localparam logic signed [31:0] COS_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic signed [63:0] value;
        logic [3:0]         degree;
        logic [3:0]         order;
        logic               last;
    } t_pval;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_cos_angle;
    logic               i_cfg_we;
    logic [3:0]         i_cfg_wdata;
    logic               o_valid;
    logic signed [63:0] o_value;
    logic [3:0]         o_degree;
    logic [3:0]         o_order_index;
    logic               o_last;

    associated_legendre_table #(.MAX_DEGREE(MAX_DEG)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cos_angle(i_cos_angle), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_value(o_value), .o_degree(o_degree),
        .o_order_index(o_order_index), .o_last(o_last)
    );

    logic signed [31:0] cos_pending[$];
    t_pval              legendre_due[$];
    logic [3:0]         lim_reg;
    int                 mismatches;
    int                 idle_cycles;
    int                 gap_left;
    bit                 gaps_on;
    bit                 send_done;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------- fixed point helpers ----------------
    function automatic logic signed [63:0] sat_mag(bit neg, logic [127:0] mag);
        if (neg) begin
            if (mag >= 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return -$signed(mag[63:0]);
        end
        if (mag > 128'h7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        return $signed(mag[63:0]);
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    function automatic logic signed [63:0] qmul(logic signed [63:0] a,
                                                logic signed [63:0] b, bit frac);
        logic [127:0] p;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        if (frac) p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        return sat_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic logic signed [63:0] qsub(logic signed [63:0] a,
                                                logic signed [63:0] b);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (d < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return d[63:0];
    endfunction

    function automatic logic signed [63:0] qdiv(logic signed [63:0] v, int unsigned d);
        logic [127:0] q;
        q = ({64'd0, abs64(v)} + d / 2) / d;
        return sat_mag(v < 0, q);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic int tix(int n, int m);
        return n * (n + 1) / 2 + m;
    endfunction

    // expected set of Pn^m values for one cosine
    task automatic predict_legendre(logic signed [31:0] c32);
        logic signed [63:0] tbl[64];
        logic signed [63:0] cq, s, sp, df, t1, t2, rad;
        int lim, cnt, k;
        t_pval pv;
        cq  = 64'(c32) * 16;
        rad = (64'sd1 <<< 60) - 64'(c32) * 64'(c32);
        if (rad < 0) rad = 0;
        s   = -$signed(int_sqrt(rad) * 16);
        lim = lim_reg > MAX_DEG ? MAX_DEG : lim_reg;
        tbl[0] = 64'sd1 <<< FRAC;
        if (lim >= 1) begin
            tbl[tix(1, 0)] = cq;
            tbl[tix(1, 1)] = s;
        end
        sp = s;
        df = 1;
        for (int m = 0; m <= lim; m++) begin
            if (m >= 2) begin
                df = df * (2 * m - 1);
                if (s == 0) begin
                    tbl[tix(m, m)] = 0;
                end else begin
                    sp = qmul(sp, s, 1'b1);
                    tbl[tix(m, m)] = qmul(df, sp, 1'b0);
                end
            end
            if (m >= 1 && m < lim) begin
                if (m >= 2 && s == 0) tbl[tix(m + 1, m)] = 0;
                else tbl[tix(m + 1, m)] = qmul((2 * m + 1) * cq, tbl[tix(m, m)], 1'b1);
            end
            for (int n = m + 2; n <= lim; n++) begin
                t1 = qmul((2 * n - 1) * cq, tbl[tix(n - 1, m)], 1'b1);
                t2 = qmul(n + m - 1, tbl[tix(n - 2, m)], 1'b0);
                tbl[tix(n, m)] = qdiv(qsub(t1, t2), n - m);
            end
        end
        cnt = (lim + 1) * (lim + 2) / 2;
        k = 0;
        for (int n = 0; n <= lim; n++) begin
            for (int m = 0; m <= n; m++) begin
                pv.value  = tbl[tix(n, m)];
                pv.degree = 4'(n);
                pv.order  = 4'(m);
                pv.last   = (k + 1 == cnt);
                legendre_due.push_back(pv);
                k++;
            end
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cos_angle <= '0;
            gap_left <= 0;
        end else if (start && !busy) begin
            predict_legendre(i_cos_angle);
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                gap_left <= $urandom_range(1, 18);
            end else if (cos_pending.size() > 0) begin
                i_cos_angle <= cos_pending.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (cos_pending.size() > 0) begin
                start <= 1'b1;
                i_cos_angle <= cos_pending.pop_front();
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (legendre_due.size() == 0) begin
                report_mismatch($sformatf("unexpected P%0d^%0d", o_degree, o_order_index));
            end else begin
                t_pval e;
                e = legendre_due.pop_front();
                if (o_value !== e.value || o_degree !== e.degree ||
                        o_order_index !== e.order || o_last !== e.last)
                    report_mismatch($sformatf("P%0d^%0d got %h n%0d m%0d l%0b exp %h l%0b",
                        e.degree, e.order, o_value, o_degree, o_order_index, o_last,
                        e.value, e.last));
            end
        end
    end

    // watchdog: cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_cos();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return $urandom();
        if (pick == 1) return $urandom_range(0, 1) ? COS_ONE : -COS_ONE;
        return $signed($urandom_range(0, 32'h7fff_ffff)) % 32'sh4000_0001
               * ($urandom_range(0, 1) ? 1 : -1);
    endfunction

    task automatic drain();
        while (cos_pending.size() > 0 || start || legendre_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [3:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        lim_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [3:0] lims[6];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mismatches = 0;
        gaps_on = 1'b1;
        lim_reg = 4'd8;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit, extremes, zero sine, out of range cosines
        cos_pending.push_back(0);
        cos_pending.push_back(COS_ONE);
        cos_pending.push_back(-COS_ONE);
        cos_pending.push_back(32'sh7fff_ffff);
        cos_pending.push_back(32'sh8000_0000);
        cos_pending.push_back(32'sh2000_0000);
        cos_pending.push_back(-32'sh3000_0001);
        cos_pending.push_back(32'sh0000_0001);
        cos_pending.push_back(32'shffff_ffff);
        cos_pending.push_back(32'sh5555_5555);
        cos_pending.push_back(32'shaaaa_aaaa);
        drain();
        set_limit(4'd0);
        cos_pending.push_back(32'sh1234_5678);
        cos_pending.push_back(-COS_ONE);
        drain();
        set_limit(4'd15);
        cos_pending.push_back(32'sh0ccc_cccc);
        cos_pending.push_back(COS_ONE);
        drain();

        // random phases of fifty cosines over several limits, then one gapless phase at limit 5
        lims = '{4'd1, 4'd2, 4'd3, 4'd8, 4'd4, 4'd9};
        foreach (lims[p]) begin
            set_limit(lims[p]);
            for (int i = 0; i < 50; i++) cos_pending.push_back(rand_cos());
            drain();
        end
        set_limit(4'd5);
        gaps_on = 1'b0;
        for (int i = 0; i < 55; i++) cos_pending.push_back(rand_cos());
        drain();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lgt_pkg.sv
rtl/lgt_mul.sv
rtl/lgt_ctrl.sv
rtl/lgt_dp.sv
rtl/associated_legendre_table.sv
sim/tb_associated_legendre_table.sv
